/* rtl/core/wsptins_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsptins_pkg
// Shared widths, read-select codes and the command and status bundles that
// join the scheduler controller to its datapath.
// ----------------------------------------------------------------------------
package wsptins_pkg;

   localparam int MAX_JOBS = 32;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int ID_W     = 16;
   localparam int TIME_W   = 10;
   localparam int WEIGHT_W = 10;
   localparam int MC_W     = 7;
   localparam int COST_W   = 36;

   // Ranking products and the trial cost pipeline.
   localparam int PROD_W = WEIGHT_W + TIME_W;
   localparam int SUM_W  = TIME_W + CNT_W;
   localparam int P_W    = MC_W + TIME_W;
   localparam int ARG_W  = ((SUM_W > P_W) ? SUM_W : P_W) + 1;
   localparam int TERM_W = WEIGHT_W + ARG_W;
   localparam int TOT_W  = (TERM_W + CNT_W > COST_W) ? TERM_W + CNT_W : COST_W + 1;

   localparam logic [TOT_W-1:0] COST_LIMIT = TOT_W'({COST_W{1'b1}});

   typedef enum logic [1:0] {
      RD_SORT_I = 2'd0,
      RD_SORT_K = 2'd1,
      RD_TRIAL  = 2'd2,
      RD_EMIT   = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       sort_init;
      logic       sort_fetch_x;
      logic       sort_read_e;
      logic       sort_mul;
      logic       sort_write_x;
      logic       sort_write_e;
      logic       ins_init;
      logic       ins_start;
      logic       trial_start;
      logic       issue;
      logic       trial_cmp;
      logic       insert;
      logic       emit_init;
      logic       emit;
      logic       clear_count;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic sort_k_zero;
      logic sort_above;
      logic trial_last;
      logic pos_last;
      logic ins_done;
      logic pipe_busy;
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/core/wspt_min_cost_insertion_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wspt_min_cost_insertion_scheduler
// Loads a set of jobs, ranks them by weight over time and builds a job
// sequence by minimum-cost insertion, then streams the sequence out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake         Word carried
//  req_     in         valid / stall     job_id, proc_time, job_weight, last_job
//  rsp_     out        valid / stall     seq_job_id, total_cost, end_of_sequence
//  csr_     in         valid / ready     machine_count (write only)
//
// Loading takes one cycle per word. After the last word the ranking runs a
// stable insertion sort; each comparison steps through the read, multiply
// and compare states. Each insertion trial takes a start step, streams its
// k+1 jobs through a six-stage cost pipeline, waits for it to drain and
// then compares the cost, and job k takes (k+1) trials. Results then leave
// at one word per cycle while rsp_ does not stall. Reset is synchronous and
// active high; it clears the job count, the machine count (to one) and all
// valid flags. The stores need no clearing pass. While computing or
// emitting, req_stall stays high; a final result may still wait in the
// output register while the next set starts loading.
//
module wspt_min_cost_insertion_scheduler
   import wsptins_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ID_W-1:0]     req_job_id,
   input  wire logic [TIME_W-1:0]   req_proc_time,
   input  wire logic [WEIGHT_W-1:0] req_job_weight,
   input  wire logic                req_last_job,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [ID_W-1:0]          rsp_seq_job_id,
   output logic [COST_W-1:0]        rsp_total_cost,
   output logic                     rsp_end_of_sequence,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [MC_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // The machine count register can take a write in any cycle.
   assign csr_ready = 1'b1;

   wsptins_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_stall    (req_stall),
      .cmd          (cmd),
      .sts          (sts)
   );

   wsptins_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_job_id          (req_job_id),
      .req_proc_time       (req_proc_time),
      .req_job_weight      (req_job_weight),
      .csr_write           (csr_valid & csr_ready),
      .csr_wdata           (csr_wdata),
      .rsp_stall           (rsp_stall),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_valid),
      .rsp_seq_job_id      (rsp_seq_job_id),
      .rsp_total_cost      (rsp_total_cost),
      .rsp_end_of_sequence (rsp_end_of_sequence)
   );

   // A trial's cost is only compared once the pipeline has fully drained.
   a_cmp_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.trial_cmp |-> !sts.pipe_busy)
      else $error("trial cost compared while the pipeline is still busy");

   // A result word is only loaded when the output register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result word loaded over one still waiting");

   // An issued element is in flight in the following cycle.
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> sts.pipe_busy)
      else $error("issued element did not enter the cost pipeline");

   // New jobs are accepted only while the cost pipeline is empty.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !sts.pipe_busy)
      else $error("input open while a trial is in progress");

endmodule
`default_nettype wire

/* rtl/core/wsptins_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsptins_ctrl
// Sequencer for loading, ranking, insertion trials and emission.
// ----------------------------------------------------------------------------
module wsptins_ctrl
   import wsptins_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_last_job,
   output logic         req_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [11:0] {
      ST_IDLE        = 12'b0000_0000_0001,
      ST_SORT_START  = 12'b0000_0000_0010,
      ST_SORT_READ   = 12'b0000_0000_0100,
      ST_SORT_MUL    = 12'b0000_0000_1000,
      ST_SORT_CMP    = 12'b0000_0001_0000,
      ST_INS_START   = 12'b0000_0010_0000,
      ST_TRIAL_START = 12'b0000_0100_0000,
      ST_TRIAL_ISSUE = 12'b0000_1000_0000,
      ST_TRIAL_DRAIN = 12'b0001_0000_0000,
      ST_TRIAL_CMP   = 12'b0010_0000_0000,
      ST_INSERT      = 12'b0100_0000_0000,
      ST_EMIT        = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_SORT_I;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_job) begin
                  cmd.sort_init = 1'b1;
                  state_in = ST_SORT_START;
               end
            end
         end
         ST_SORT_START: begin
            cmd.rd_sel = RD_SORT_I;
            if (sts.sort_done) begin
               cmd.ins_init = 1'b1;
               state_in = ST_INS_START;
            end else begin
               cmd.sort_fetch_x = 1'b1;
               state_in = ST_SORT_READ;
            end
         end
         ST_SORT_READ: begin
            cmd.rd_sel = RD_SORT_K;
            if (sts.sort_k_zero) begin
               cmd.sort_write_x = 1'b1;
               state_in = ST_SORT_START;
            end else begin
               cmd.sort_read_e = 1'b1;
               state_in = ST_SORT_MUL;
            end
         end
         ST_SORT_MUL: begin
            cmd.sort_mul = 1'b1;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (sts.sort_above) begin
               cmd.sort_write_e = 1'b1;
               state_in = ST_SORT_READ;
            end else begin
               cmd.sort_write_x = 1'b1;
               state_in = ST_SORT_START;
            end
         end
         ST_INS_START: begin
            if (sts.ins_done) begin
               cmd.emit_init = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.ins_start = 1'b1;
               state_in = ST_TRIAL_START;
            end
         end
         ST_TRIAL_START: begin
            cmd.trial_start = 1'b1;
            state_in = ST_TRIAL_ISSUE;
         end
         ST_TRIAL_ISSUE: begin
            cmd.rd_sel = RD_TRIAL;
            cmd.issue = 1'b1;
            if (sts.trial_last) begin
               state_in = ST_TRIAL_DRAIN;
            end
         end
         ST_TRIAL_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_TRIAL_CMP;
            end
         end
         ST_TRIAL_CMP: begin
            cmd.trial_cmp = 1'b1;
            if (sts.pos_last) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_TRIAL_START;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in = ST_INS_START;
         end
         ST_EMIT: begin
            cmd.rd_sel = RD_EMIT;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_count = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/wsptins_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsptins_datapath
// Job stores, ranking comparator, sequence register, trial cost pipeline
// and the result output register.
// ----------------------------------------------------------------------------
module wsptins_datapath
   import wsptins_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [ID_W-1:0]     req_job_id,
   input  wire logic [TIME_W-1:0]   req_proc_time,
   input  wire logic [WEIGHT_W-1:0] req_job_weight,
   input  wire logic                csr_write,
   input  wire logic [MC_W-1:0]     csr_wdata,
   input  wire logic                rsp_stall,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   output logic                     rsp_valid,
   output logic [ID_W-1:0]          rsp_seq_job_id,
   output logic [COST_W-1:0]        rsp_total_cost,
   output logic                     rsp_end_of_sequence
);

   // Stores and sequence.
   logic [ID_W-1:0]     id_mem_ff   [MAX_JOBS];
   logic [ID_W-1:0]     id_mem_in   [MAX_JOBS];
   logic [TIME_W-1:0]   time_mem_ff [MAX_JOBS];
   logic [TIME_W-1:0]   time_mem_in [MAX_JOBS];
   logic [WEIGHT_W-1:0] wt_mem_ff   [MAX_JOBS];
   logic [WEIGHT_W-1:0] wt_mem_in   [MAX_JOBS];
   logic [IDX_W-1:0]    seq_ff      [MAX_JOBS];
   logic [IDX_W-1:0]    seq_in      [MAX_JOBS];

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MC_W-1:0]  mc_ff, mc_in;

   // Ranking.
   logic [CNT_W-1:0]    sort_i_ff, sort_i_in;
   logic [IDX_W-1:0]    sort_k_ff, sort_k_in;
   logic [ID_W-1:0]     xid_ff, xid_in, eid_ff, eid_in;
   logic [TIME_W-1:0]   xt_ff, xt_in, et_ff, et_in;
   logic [WEIGHT_W-1:0] xw_ff, xw_in, ew_ff, ew_in;
   logic [PROD_W-1:0]   sa_ff, sa_in, sb_ff, sb_in;

   // Insertion.
   logic [CNT_W-1:0] ins_k_ff, ins_k_in;
   logic [IDX_W-1:0] pos_ff, pos_in, elem_ff, elem_in, bpos_ff, bpos_in;
   logic [TOT_W-1:0] best_ff, best_in;

   // Trial cost pipeline.
   logic                v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                v4_ff, v4_in, v5_ff, v5_in;
   logic [TIME_W-1:0]   t1_ff, t1_in, mx_ff, mx_in;
   logic [WEIGHT_W-1:0] w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in, w4_ff, w4_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, s3_ff, s3_in;
   logic [P_W-1:0]      p3_ff, p3_in;
   logic [ARG_W-1:0]    a4_ff, a4_in;
   logic [TERM_W-1:0]   term5_ff, term5_in;
   logic [TOT_W-1:0]    total_ff, total_in;

   // Output register.
   logic              rv_ff, rv_in, reos_ff, reos_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [COST_W-1:0] rcost_ff, rcost_in;

   logic [IDX_W-1:0]    rd_addr, seq_addr, trial_job, wr_addr;
   logic [ID_W-1:0]     rd_id, wr_id;
   logic [TIME_W-1:0]   rd_time, wr_time;
   logic [WEIGHT_W-1:0] rd_wt, wr_wt;
   logic                wr_en;
   logic [MC_W-1:0]     mm1;
   logic [COST_W-1:0]   cost_sat;

   assign mm1 = (mc_ff == '0) ? '0 : mc_ff - MC_W'(1);
   assign cost_sat = (best_ff > COST_LIMIT) ? '1 : best_ff[COST_W-1:0];

   // Element of the trial sequence: the new job sits at the trial position.
   assign seq_addr  = (elem_ff < pos_ff) ? elem_ff : elem_ff - IDX_W'(1);
   assign trial_job = (elem_ff == pos_ff) ? ins_k_ff[IDX_W-1:0] : seq_ff[seq_addr];

   always_comb begin
      case (cmd.rd_sel)
         RD_SORT_I: rd_addr = sort_i_ff[IDX_W-1:0];
         RD_SORT_K: rd_addr = sort_k_ff - IDX_W'(1);
         RD_TRIAL:  rd_addr = trial_job;
         RD_EMIT:   rd_addr = seq_ff[elem_ff];
         default:   rd_addr = sort_i_ff[IDX_W-1:0];
      endcase
   end

   assign rd_id   = id_mem_ff[rd_addr];
   assign rd_time = time_mem_ff[rd_addr];
   assign rd_wt   = wt_mem_ff[rd_addr];

   // Single store write port: loading, or a shift or placement step of the ranking.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sort_k_ff;
      wr_id   = xid_ff;
      wr_time = xt_ff;
      wr_wt   = xw_ff;
      if (cmd.load) begin
         wr_en   = (cnt_ff < CNT_W'(MAX_JOBS));
         wr_addr = cnt_ff[IDX_W-1:0];
         wr_id   = req_job_id;
         wr_time = req_proc_time;
         wr_wt   = req_job_weight;
      end else if (cmd.sort_write_e) begin
         wr_en   = 1'b1;
         wr_id   = eid_ff;
         wr_time = et_ff;
         wr_wt   = ew_ff;
      end else if (cmd.sort_write_x) begin
         wr_en   = 1'b1;
      end
   end

   always_comb begin
      id_mem_in   = id_mem_ff;
      time_mem_in = time_mem_ff;
      wt_mem_in   = wt_mem_ff;
      if (wr_en) begin
         id_mem_in[wr_addr]   = wr_id;
         time_mem_in[wr_addr] = wr_time;
         wt_mem_in[wr_addr]   = wr_wt;
      end
   end

   // Insertion opens a gap at the best position in one step.
   always_comb begin
      seq_in = seq_ff;
      if (cmd.insert) begin
         for (int e = 0; e < MAX_JOBS; e++) begin
            if (IDX_W'(e) == bpos_ff) begin
               seq_in[e] = ins_k_ff[IDX_W-1:0];
            end else if ((e > 0) && (IDX_W'(e) > bpos_ff)) begin
               seq_in[e] = seq_ff[(e > 0) ? e - 1 : 0];
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_count) begin
         cnt_in = '0;
      end else if (cmd.load && (cnt_ff < CNT_W'(MAX_JOBS))) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      mc_in = csr_write ? csr_wdata : mc_ff;

      sort_i_in = sort_i_ff;
      sort_k_in = sort_k_ff;
      xid_in = xid_ff; xt_in = xt_ff; xw_in = xw_ff;
      eid_in = eid_ff; et_in = et_ff; ew_in = ew_ff;
      sa_in = sa_ff;   sb_in = sb_ff;
      if (cmd.sort_init) begin
         sort_i_in = CNT_W'(1);
      end
      if (cmd.sort_fetch_x) begin
         xid_in = rd_id; xt_in = rd_time; xw_in = rd_wt;
         sort_k_in = sort_i_ff[IDX_W-1:0];
      end
      if (cmd.sort_read_e) begin
         eid_in = rd_id; et_in = rd_time; ew_in = rd_wt;
      end
      if (cmd.sort_mul) begin
         sa_in = PROD_W'(xw_ff) * PROD_W'(et_ff);
         sb_in = PROD_W'(ew_ff) * PROD_W'(xt_ff);
      end
      if (cmd.sort_write_e) begin
         sort_k_in = sort_k_ff - IDX_W'(1);
      end
      if (cmd.sort_write_x) begin
         sort_i_in = sort_i_ff + CNT_W'(1);
      end

      ins_k_in = ins_k_ff;
      pos_in   = pos_ff;
      elem_in  = elem_ff;
      best_in  = best_ff;
      bpos_in  = bpos_ff;
      if (cmd.ins_init) begin
         ins_k_in = '0;
      end
      if (cmd.ins_start) begin
         best_in = '1;
         bpos_in = '0;
         pos_in  = '0;
      end
      if (cmd.trial_start || cmd.emit_init) begin
         elem_in = '0;
      end
      if (cmd.issue || cmd.emit) begin
         elem_in = elem_ff + IDX_W'(1);
      end
      if (cmd.trial_cmp) begin
         // Equal cost moves the choice to the later position.
         if (total_ff <= best_ff) begin
            best_in = total_ff;
            bpos_in = pos_ff;
         end
         pos_in = pos_ff + IDX_W'(1);
      end
      if (cmd.insert) begin
         ins_k_in = ins_k_ff + CNT_W'(1);
      end

      v1_in = cmd.issue;
      t1_in = rd_time;
      w1_in = rd_wt;
      v2_in = v1_ff;
      w2_in = w1_ff;
      sum_in = sum_ff;
      mx_in  = mx_ff;
      if (cmd.trial_start) begin
         sum_in = '0;
         mx_in  = '0;
      end else if (v1_ff) begin
         sum_in = sum_ff + SUM_W'(t1_ff);
         mx_in  = (t1_ff > mx_ff) ? t1_ff : mx_ff;
      end
      v3_in = v2_ff;
      p3_in = P_W'(mm1) * P_W'(mx_ff);
      s3_in = sum_ff;
      w3_in = w2_ff;
      v4_in = v3_ff;
      a4_in = ARG_W'(s3_ff) + ARG_W'(p3_ff);
      w4_in = w3_ff;
      v5_in = v4_ff;
      term5_in = TERM_W'(w4_ff) * TERM_W'(a4_ff);
      total_in = total_ff;
      if (cmd.trial_start) begin
         total_in = '0;
      end else if (v5_ff) begin
         total_in = total_ff + TOT_W'(term5_ff);
      end

      rv_in    = rv_ff;
      rid_in   = rid_ff;
      rcost_in = rcost_ff;
      reos_in  = reos_ff;
      if (cmd.emit) begin
         rv_in    = 1'b1;
         rid_in   = rd_id;
         rcost_in = sts.emit_last ? cost_sat : '0;
         reos_in  = sts.emit_last;
      end else if (!rsp_stall) begin
         rv_in = 1'b0;
      end
   end

   always_comb begin
      sts.sort_done   = (sort_i_ff == cnt_ff);
      sts.sort_k_zero = (sort_k_ff == '0);
      sts.sort_above  = (sa_ff > sb_ff);
      sts.trial_last  = (CNT_W'(elem_ff) == ins_k_ff);
      sts.pos_last    = (CNT_W'(pos_ff) == ins_k_ff);
      sts.ins_done    = (ins_k_ff == cnt_ff);
      sts.pipe_busy   = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
      sts.out_free    = !rv_ff || !rsp_stall;
      sts.emit_last   = (CNT_W'(elem_ff) == cnt_ff - CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         mc_ff  <= MC_W'(1);
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         rv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         mc_ff  <= mc_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         v5_ff  <= v5_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      id_mem_ff   <= id_mem_in;
      time_mem_ff <= time_mem_in;
      wt_mem_ff   <= wt_mem_in;
      seq_ff      <= seq_in;
      sort_i_ff   <= sort_i_in;
      sort_k_ff   <= sort_k_in;
      xid_ff <= xid_in; xt_ff <= xt_in; xw_ff <= xw_in;
      eid_ff <= eid_in; et_ff <= et_in; ew_ff <= ew_in;
      sa_ff  <= sa_in;  sb_ff <= sb_in;
      ins_k_ff <= ins_k_in;
      pos_ff   <= pos_in;
      elem_ff  <= elem_in;
      best_ff  <= best_in;
      bpos_ff  <= bpos_in;
      t1_ff <= t1_in; w1_ff <= w1_in; w2_ff <= w2_in;
      sum_ff <= sum_in; mx_ff <= mx_in;
      p3_ff <= p3_in; s3_ff <= s3_in; w3_ff <= w3_in;
      a4_ff <= a4_in; w4_ff <= w4_in;
      term5_ff <= term5_in;
      total_ff <= total_in;
      rid_ff   <= rid_in;
      rcost_ff <= rcost_in;
      reos_ff  <= reos_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_seq_job_id      = rid_ff;
   assign rsp_total_cost      = rcost_ff;
   assign rsp_end_of_sequence = reos_ff;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WSPT minimum-cost insertion scheduler. Job sets
// are loaded over req_, each emitted sequence on rsp_ is compared word by word
// with a behavioural scheduler kept inside the bench, and the machine count is
// rewritten over csr_ between sets.
// ----------------------------------------------------------------------------
module tb_top;
   import wsptins_pkg::*;

   // Watchdog: longest quiet spell is one full 32-job computation plus the
   // long receiver hold-off, taken several times over.
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 3000;
   localparam int RANDOM_ITEMS   = 320;
   localparam int NO_CFG         = -1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ID_W-1:0]     req_job_id = '0;
   logic [TIME_W-1:0]   req_proc_time = '0;
   logic [WEIGHT_W-1:0] req_job_weight = '0;
   logic                req_last_job = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ID_W-1:0]     rsp_seq_job_id;
   logic [COST_W-1:0]   rsp_total_cost;
   logic                rsp_end_of_sequence;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MC_W-1:0]     csr_wdata = '0;

   always #1 clock = ~clock;

   wspt_min_cost_insertion_scheduler u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_job_id          (req_job_id),
      .req_proc_time       (req_proc_time),
      .req_job_weight      (req_job_weight),
      .req_last_job        (req_last_job),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_seq_job_id      (rsp_seq_job_id),
      .rsp_total_cost      (rsp_total_cost),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Behavioural scheduler. It mirrors the job stores, the machine count and
   // the sequence under construction, and on the last job of a set it appends
   // the whole expected sequence to seq_words_due when publish is set.
   // ------------------------------------------------------------------------
   typedef struct {
      logic [ID_W-1:0]   id;
      logic [COST_W-1:0] cost;
      logic              eos;
   } seq_word_type;

   seq_word_type      seq_words_due[$];
   logic [ID_W-1:0]   job_ids   [MAX_JOBS];
   logic [TIME_W-1:0] job_times [MAX_JOBS];
   logic [WEIGHT_W-1:0] job_wts [MAX_JOBS];
   int                order     [MAX_JOBS];
   int                jobs_held = 0;
   logic [MC_W-1:0]   machines  = 1;
   int                errors    = 0;

   // Cost of the sequence of length len with ranked job k placed at pos.
   function automatic longint unsigned insertion_cost(int len, int pos, int k,
                                                      longint unsigned mm1);
      longint unsigned total, run_sum, run_max;
      int j;
      total = 0; run_sum = 0; run_max = 0;
      for (int i = 0; i <= len; i++) begin
         if (i < pos) j = order[i];
         else if (i == pos) j = k;
         else j = order[i-1];
         run_sum += job_times[j];
         if (job_times[j] > run_max) run_max = job_times[j];
         total += longint'(job_wts[j]) * (run_sum + mm1 * run_max);
      end
      return total;
   endfunction

   task automatic schedule_set(input bit publish);
      int n, len, best_pos, k;
      longint unsigned mm1, best, c, total;
      logic [ID_W-1:0] ti;
      logic [TIME_W-1:0] tt;
      logic [WEIGHT_W-1:0] tw;
      seq_word_type w;
      n = jobs_held;
      mm1 = (machines == 0) ? 0 : machines - 1;
      // Stable ranking by weight over time, largest ratio first.
      for (int i = 1; i < n; i++) begin
         k = i;
         while (k > 0 && longint'(job_wts[k]) * job_times[k-1] >
                         longint'(job_wts[k-1]) * job_times[k]) begin
            ti = job_ids[k];   job_ids[k] = job_ids[k-1];     job_ids[k-1] = ti;
            tt = job_times[k]; job_times[k] = job_times[k-1]; job_times[k-1] = tt;
            tw = job_wts[k];   job_wts[k] = job_wts[k-1];     job_wts[k-1] = tw;
            k--;
         end
      end
      order[0] = 0;
      len = 1;
      for (k = 1; k < n; k++) begin
         best = '1;
         best_pos = 0;
         // A tie goes to the later position, hence the <=.
         for (int pos = 0; pos <= len; pos++) begin
            c = insertion_cost(len, pos, k, mm1);
            if (c <= best) begin
               best = c;
               best_pos = pos;
            end
         end
         for (int i = len; i > best_pos; i--) order[i] = order[i-1];
         order[best_pos] = k;
         len++;
      end
      if (n == 1) total = insertion_cost(0, 0, order[0], mm1);
      else total = insertion_cost(n-1, n-1, order[n-1], mm1);
      if (total > longint'(COST_LIMIT)) total = 64'(COST_LIMIT);
      if (publish) begin
         for (int i = 0; i < n; i++) begin
            w.id   = job_ids[order[i]];
            w.cost = (i == n-1) ? total[COST_W-1:0] : '0;
            w.eos  = (i == n-1);
            seq_words_due.insert(seq_words_due.size(), w);
         end
      end
      jobs_held = 0;
   endtask

   // Record an accepted job; jobs beyond a full store are dropped.
   task automatic absorb_job(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t,
                             input logic [WEIGHT_W-1:0] wt, input logic last,
                             input bit publish);
      if (jobs_held < MAX_JOBS) begin
         job_ids[jobs_held] = id;
         job_times[jobs_held] = t;
         job_wts[jobs_held] = wt;
         jobs_held++;
      end
      if (last && jobs_held > 0) schedule_set(publish);
   endtask

   // ------------------------------------------------------------------------
   // Sender side. calm suppresses random idling on both channels.
   // ------------------------------------------------------------------------
   bit calm = 1'b0;
   int accepted_cycles = 0;

   task automatic send_job(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t,
                           input logic [WEIGHT_W-1:0] wt, input logic last,
                           input bit publish);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_job_id     <= id;
      req_proc_time  <= t;
      req_job_weight <= wt;
      req_last_job   <= last;
      do @(posedge clock); while (req_stall);
      absorb_job(id, t, wt, last, publish);
   endtask

   // Wait for every due word, then let the block settle before anything that
   // needs it idle.
   task automatic drain;
      req_valid <= 1'b0;
      while (seq_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_machines(input logic [MC_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      machines = value;
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stall, plus a long hold-off on request from the
   // stimulus process, counted here in cycles.
   // ------------------------------------------------------------------------
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 7);
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
   endtask

   // Every accepted result word is checked against the oldest due word.
   always @(posedge clock) begin
      seq_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (seq_words_due.size() == 0) begin
            report_mismatch("unexpected word, id", rsp_seq_job_id, 0);
         end else begin
            w = seq_words_due.pop_front();
            if (rsp_seq_job_id !== w.id) report_mismatch("seq_job_id", rsp_seq_job_id, w.id);
            if (rsp_total_cost !== w.cost)
               report_mismatch("total_cost", rsp_total_cost, w.cost);
            if (rsp_end_of_sequence !== w.eos)
               report_mismatch("end_of_sequence", rsp_end_of_sequence, w.eos);
         end
      end
   end

   // Watchdog: cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         accepted_cycles <= 0;
      end else if (accepted_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d words still due", seq_words_due.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         accepted_cycles <= accepted_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Directed table. Single-job sets carry their cost written out by hand:
   // w * (t + (m-1) * t). Other rows go through the behavioural scheduler.
   // ------------------------------------------------------------------------
   typedef struct {
      int                cfg;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] t;
      logic [WEIGHT_W-1:0] wt;
      logic              last;
      bit                typed;
      longint unsigned   cost;
   } dir_row_type;

   localparam int DIR_ROWS = 14;
   dir_row_type dir_tab [DIR_ROWS];

   initial begin
      int items, set_len, cfg_gap;
      logic [TIME_W-1:0] t;
      logic [WEIGHT_W-1:0] wt;
      seq_word_type w;

      // Largest fields, one machine.
      dir_tab[0]  = '{1,      16'hFFFF, 10'd1023, 10'd1023, 1'b1, 1'b1, 64'd1046529};
      // Smallest fields, zero weight gives zero cost.
      dir_tab[1]  = '{NO_CFG, 16'h0000, 10'd1,    10'd0,    1'b1, 1'b1, 64'd0};
      // Largest machine count the register can hold.
      dir_tab[2]  = '{127,    16'h1234, 10'd1023, 10'd1023, 1'b1, 1'b1, 64'd132909183};
      // A machine count of zero behaves as one.
      dir_tab[3]  = '{0,      16'h5A5A, 10'd3,    10'd5,    1'b1, 1'b1, 64'd15};
      // Mixed three-job set on a machine count of 64.
      dir_tab[4]  = '{64,     16'h0011, 10'd7,    10'd2,    1'b0, 1'b0, 64'd0};
      dir_tab[5]  = '{NO_CFG, 16'h0022, 10'd1,    10'd9,    1'b0, 1'b0, 64'd0};
      dir_tab[6]  = '{NO_CFG, 16'h0033, 10'd500,  10'd1000, 1'b1, 1'b0, 64'd0};
      // Equal ratios keep load order.
      dir_tab[7]  = '{1,      16'h0101, 10'd4,    10'd2,    1'b0, 1'b0, 64'd0};
      dir_tab[8]  = '{NO_CFG, 16'h0102, 10'd2,    10'd1,    1'b0, 1'b0, 64'd0};
      dir_tab[9]  = '{NO_CFG, 16'h0103, 10'd6,    10'd3,    1'b1, 1'b0, 64'd0};
      // Zero processing times.
      dir_tab[10] = '{2,      16'h0201, 10'd0,    10'd5,    1'b0, 1'b0, 64'd0};
      dir_tab[11] = '{NO_CFG, 16'h0202, 10'd0,    10'd0,    1'b0, 1'b0, 64'd0};
      dir_tab[12] = '{NO_CFG, 16'h0203, 10'd7,    10'd3,    1'b1, 1'b0, 64'd0};
      // Two identical jobs, so insertion ties go to the later position.
      dir_tab[13] = '{NO_CFG, 16'h0301, 10'd9,    10'd9,    1'b1, 1'b0, 64'd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_tab[r].cfg != NO_CFG) write_machines(MC_W'(dir_tab[r].cfg));
         if (r == 13) begin
            // Its twin goes in first, through the same path.
            send_job(16'h0300, 10'd9, 10'd9, 1'b0, 1'b1);
         end
         send_job(dir_tab[r].id, dir_tab[r].t, dir_tab[r].wt, dir_tab[r].last,
                  !dir_tab[r].typed);
         if (dir_tab[r].typed) begin
            w.id = dir_tab[r].id;
            w.cost = dir_tab[r].cost[COST_W-1:0];
            w.eos = 1'b1;
            seq_words_due.insert(seq_words_due.size(), w);
         end
      end

      // A full store: the 33rd and 34th jobs are dropped, the last still runs.
      write_machines(MC_W'(3));
      for (int i = 0; i < MAX_JOBS + 2; i++)
         send_job(ID_W'(16'h4000 + i), TIME_W'($urandom_range(1023)),
                  WEIGHT_W'($urandom_range(1023)), i == MAX_JOBS + 1, 1'b1);

      // Receiver hold-off: a small set is computed and parked while the next
      // set keeps knocking on req_ until the block stalls it.
      drain();
      hold_req <= hold_req + 1;
      for (int i = 0; i < 4; i++)
         send_job(ID_W'($urandom), TIME_W'($urandom_range(1, 1023)),
                  WEIGHT_W'($urandom_range(1023)), i == 3, 1'b1);
      for (int i = 0; i < 5; i++)
         send_job(ID_W'($urandom), TIME_W'($urandom_range(1, 1023)),
                  WEIGHT_W'($urandom_range(1023)), i == 4, 1'b1);

      // Random sets: mostly small, now and then nearly full, full or overfull,
      // with ties and zero times mixed in. The machine count changes every few sets.
      items = 0;
      cfg_gap = 0;
      while (items < RANDOM_ITEMS) begin
         calm <= (items > 120 && items < 200);
         if (cfg_gap == 0) begin
            case ($urandom_range(5))
               0: write_machines(MC_W'(0));
               1: write_machines(MC_W'(1));
               2: write_machines(MC_W'(64));
               3: write_machines(MC_W'(127));
               default: write_machines(MC_W'($urandom_range(2, 63)));
            endcase
            cfg_gap = $urandom_range(2, 6);
         end
         cfg_gap--;
         if ($urandom_range(19) == 0) set_len = $urandom_range(MAX_JOBS - 4, MAX_JOBS + 1);
         else set_len = $urandom_range(1, 7);
         for (int i = 0; i < set_len; i++) begin
            case ($urandom_range(9))
               0: begin t = 10'd0; wt = WEIGHT_W'($urandom); end
               1: begin t = 10'd8; wt = 10'd8; end
               2: begin t = 10'd1023; wt = 10'd1023; end
               default: begin
                  t = TIME_W'($urandom_range(1, 1023));
                  wt = WEIGHT_W'($urandom);
               end
            endcase
            send_job(ID_W'($urandom), t, wt, i == set_len - 1, 1'b1);
            items++;
         end
         // Now and then the sender waits for the whole sequence.
         if ($urandom_range(7) == 0) drain();
      end

      drain();
      if (errors == 0 && seq_words_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
